[rtl/gcpt_pkg.sv]
// ----------------------------------------------------------------------------
// gcpt_pkg
// Shared types and constants of the pairwise geometric consistency test.
// ----------------------------------------------------------------------------
package gcpt_pkg;

    // Distances and limits are unsigned, unit 1/1024.
    localparam int DIST_W     = 22;
    localparam int REACH_SQ_W = 2 * DIST_W;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_REACH = 2'd0;
    localparam logic [1:0] REG_CAND  = 2'd1;
    localparam logic [1:0] REG_CONS  = 2'd2;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [REACH_SQ_W-1:0] reach_sq;
        logic [DIST_W-1:0]     candidate_limit;
        logic [DIST_W-1:0]     consistency_resolution;
    } cfg_t;

endpackage

[rtl/geometric_consistency_pair_test.sv]
// ----------------------------------------------------------------------------
// geometric_consistency_pair_test
// Pairwise geometric consistency distance of two point correspondences.
// ----------------------------------------------------------------------------
// Each request carries two correspondences, each a model centroid and a scene
// centroid in signed fixed point at 1/1024 unit. The block returns one result
// per request: the absolute difference of the floored scene and model
// distances, or the saturated maximum distance with out_of_reach set when the
// scene separation exceeds the reach limit, together with the candidate and
// consistency flags. The block is fully pipelined and takes one request every
// clock cycle unless stalled. It has three front stages for differences,
// squares and sums with the reach test, one square-root stage per root bit
// (COORD_BITS + 1 of them), and two back stages for the difference and flags,
// the last being the result register. The whole pipeline moves together; it
// holds only while a result waits in the output register and is not taken, so
// s_ready is low exactly then. The user must write the three limits through
// the APB-style port while the block is idle; the block does not enforce this.
// The squared reach limit is registered and follows a write in the next cycle.
// ----------------------------------------------------------------------------
module geometric_consistency_pair_test #(
    parameter int COORD_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcpt_pkg::ADDR_W-1:0] paddr,
    input  logic [gcpt_pkg::DATA_W-1:0] pwdata,
    output logic [gcpt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // Request channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_BITS-1:0] s_model_a_x,
    input  logic signed [COORD_BITS-1:0] s_model_a_y,
    input  logic signed [COORD_BITS-1:0] s_model_a_z,
    input  logic signed [COORD_BITS-1:0] s_scene_a_x,
    input  logic signed [COORD_BITS-1:0] s_scene_a_y,
    input  logic signed [COORD_BITS-1:0] s_scene_a_z,
    input  logic signed [COORD_BITS-1:0] s_model_b_x,
    input  logic signed [COORD_BITS-1:0] s_model_b_y,
    input  logic signed [COORD_BITS-1:0] s_model_b_z,
    input  logic signed [COORD_BITS-1:0] s_scene_b_x,
    input  logic signed [COORD_BITS-1:0] s_scene_b_y,
    input  logic signed [COORD_BITS-1:0] s_scene_b_z,
    // Result channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [gcpt_pkg::DIST_W-1:0] m_pair_distance,
    output logic                        m_out_of_reach,
    output logic                        m_is_candidate,
    output logic                        m_is_consistent
);
    import gcpt_pkg::*;

    localparam int SUM_W = 2 * COORD_BITS + 2;

    cfg_t                  cfg;
    logic                  en;
    logic [COORD_BITS-1:0] coord [12];
    logic                  f_valid, f_far;
    logic [SUM_W-1:0]      sums [2];
    logic                  r_valid, r_far;
    logic [COORD_BITS:0]   roots [2];

    // Every stage advances unless a finished result is stuck at the output.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Coordinates in request order: model a, scene a, model b, scene b.
    assign coord[0]  = s_model_a_x;
    assign coord[1]  = s_model_a_y;
    assign coord[2]  = s_model_a_z;
    assign coord[3]  = s_scene_a_x;
    assign coord[4]  = s_scene_a_y;
    assign coord[5]  = s_scene_a_z;
    assign coord[6]  = s_model_b_x;
    assign coord[7]  = s_model_b_y;
    assign coord[8]  = s_model_b_z;
    assign coord[9]  = s_scene_b_x;
    assign coord[10] = s_scene_b_y;
    assign coord[11] = s_scene_b_z;

    gcpt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gcpt_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .coord     (coord),
        .reach_sq  (cfg.reach_sq),
        .out_valid (f_valid),
        .scene_sq  (sums[0]),
        .model_sq  (sums[1]),
        .is_far    (f_far)
    );

    // Lane 0 carries the scene radicand, lane 1 the model radicand.
    gcpt_root_pipe #(.COORD_BITS(COORD_BITS)) u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_far    (f_far),
        .in_rad    (sums),
        .out_valid (r_valid),
        .out_far   (r_far),
        .out_root  (roots)
    );

    gcpt_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (r_valid),
        .in_far         (r_far),
        .scene_root     (roots[0]),
        .model_root     (roots[1]),
        .cfg            (cfg),
        .out_valid      (m_valid),
        .out_distance   (m_pair_distance),
        .out_far        (m_out_of_reach),
        .out_candidate  (m_is_candidate),
        .out_consistent (m_is_consistent)
    );

endmodule

[rtl/gcpt_regs.sv]
// ----------------------------------------------------------------------------
// gcpt_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module gcpt_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcpt_pkg::ADDR_W-1:0] paddr,
    input  logic [gcpt_pkg::DATA_W-1:0] pwdata,
    output logic [gcpt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output gcpt_pkg::cfg_t              cfg
);
    import gcpt_pkg::*;

    logic [DIST_W-1:0]     reach_reg;
    logic [DIST_W-1:0]     cand_reg;
    logic [DIST_W-1:0]     cons_reg;
    logic [REACH_SQ_W-1:0] reach_sq_reg;
    logic [1:0]            idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_reg <= DIST_MAX;
            cand_reg  <= '0;
            cons_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_REACH: reach_reg <= pwdata[DIST_W-1:0];
                REG_CAND:  cand_reg  <= pwdata[DIST_W-1:0];
                REG_CONS:  cons_reg  <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // The squared reach limit is registered and follows the register in the next cycle.
    always_ff @(posedge aclk) begin
        reach_sq_reg <= REACH_SQ_W'(reach_reg) * REACH_SQ_W'(reach_reg);
    end

    always_comb begin
        unique case (idx)
            REG_REACH: prdata = {{(DATA_W-DIST_W){1'b0}}, reach_reg};
            REG_CAND:  prdata = {{(DATA_W-DIST_W){1'b0}}, cand_reg};
            REG_CONS:  prdata = {{(DATA_W-DIST_W){1'b0}}, cons_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.reach_sq               = reach_sq_reg;
    assign cfg.candidate_limit        = cand_reg;
    assign cfg.consistency_resolution = cons_reg;

endmodule

[rtl/gcpt_front.sv]
// ----------------------------------------------------------------------------
// gcpt_front
// Differences, squares and sums of squares, with the reach test.
// ----------------------------------------------------------------------------
module gcpt_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [COORD_BITS-1:0]           coord [12],
    input  logic [gcpt_pkg::REACH_SQ_W-1:0] reach_sq,
    output logic                            out_valid,
    output logic [2*COORD_BITS+1:0]         scene_sq,
    output logic [2*COORD_BITS+1:0]         model_sq,
    output logic                            is_far
);
    import gcpt_pkg::*;

    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQR_W = 2 * COORD_BITS + 1;
    localparam int SUM_W = 2 * COORD_BITS + 2;
    localparam int CMP_W = ((SUM_W > REACH_SQ_W) ? SUM_W : REACH_SQ_W) + 1;

    logic             v1_reg, v2_reg, v3_reg;
    logic [MAG_W-1:0] mag_next [6];
    logic [MAG_W-1:0] mag_reg  [6];
    logic [SQR_W-1:0] sq_reg   [6];
    logic [SUM_W-1:0] scene_next, model_next;
    logic [SUM_W-1:0] scene_reg, model_reg;
    logic             far_next, far_reg;

    // Lanes 0 to 2 are the scene axes, lanes 3 to 5 the model axes.
    always_comb begin
        logic [COORD_BITS-1:0] pa, pb;
        logic signed [MAG_W-1:0] d;
        for (int l = 0; l < 6; l++) begin
            pa = coord[(l < 3) ? l + 3 : l - 3];
            pb = coord[(l < 3) ? l + 9 : l + 3];
            d  = $signed({pa[COORD_BITS-1], pa}) - $signed({pb[COORD_BITS-1], pb});
            mag_next[l] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
        end
    end

    always_comb begin
        scene_next = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]} + {1'b0, sq_reg[2]};
        model_next = {1'b0, sq_reg[3]} + {1'b0, sq_reg[4]} + {1'b0, sq_reg[5]};
        far_next   = {{(CMP_W-SUM_W){1'b0}}, scene_next}
                   > {{(CMP_W-REACH_SQ_W){1'b0}}, reach_sq};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                mag_reg[l] <= mag_next[l];
                sq_reg[l]  <= SQR_W'(mag_reg[l]) * SQR_W'(mag_reg[l]);
            end
            scene_reg <= scene_next;
            model_reg <= model_next;
            far_reg   <= far_next;
        end
    end

    assign out_valid = v3_reg;
    assign scene_sq  = scene_reg;
    assign model_sq  = model_reg;
    assign is_far    = far_reg;

endmodule

[rtl/gcpt_root_pipe.sv]
// ----------------------------------------------------------------------------
// gcpt_root_pipe
// Pipelined integer square root, one root bit per stage, two lanes.
// ----------------------------------------------------------------------------
module gcpt_root_pipe #(
    parameter int COORD_BITS = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic                    in_far,
    input  logic [2*COORD_BITS+1:0] in_rad [2],
    output logic                    out_valid,
    output logic                    out_far,
    output logic [COORD_BITS:0]     out_root [2]
);
    localparam int RB    = COORD_BITS + 1;
    localparam int SUM_W = 2 * RB;

    logic [SUM_W-1:0] rad_reg  [RB][2];
    logic [RB+1:0]    rem_reg  [RB][2];
    logic [RB-1:0]    root_reg [RB][2];
    logic             vld_reg  [RB];
    logic             far_reg  [RB];

    for (genvar g = 0; g < RB; g++) begin : g_stage
        logic [SUM_W-1:0] rad_in  [2];
        logic [RB+1:0]    rem_in  [2];
        logic [RB-1:0]    root_in [2];
        logic             vld_in, far_in;

        if (g == 0) begin : g_first
            assign vld_in = in_valid;
            assign far_in = in_far;
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign rad_in[l]  = in_rad[l];
                assign rem_in[l]  = '0;
                assign root_in[l] = '0;
            end
        end else begin : g_rest
            assign vld_in = vld_reg[g-1];
            assign far_in = far_reg[g-1];
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign rad_in[l]  = rad_reg[g-1][l];
                assign rem_in[l]  = rem_reg[g-1][l];
                assign root_in[l] = root_reg[g-1][l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= vld_in;
            end
        end

        // Bring down the next two radicand bits and try the next root bit.
        always_ff @(posedge aclk) begin
            logic [RB+1:0] acc, trial;
            if (en) begin
                far_reg[g] <= far_in;
                for (int l = 0; l < 2; l++) begin
                    acc   = {rem_in[l][RB-1:0], rad_in[l][SUM_W-1 -: 2]};
                    trial = {root_in[l], 2'b01};
                    rad_reg[g][l] <= {rad_in[l][SUM_W-3:0], 2'b00};
                    if (acc >= trial) begin
                        rem_reg[g][l]  <= acc - trial;
                        root_reg[g][l] <= {root_in[l][RB-2:0], 1'b1};
                    end else begin
                        rem_reg[g][l]  <= acc;
                        root_reg[g][l] <= {root_in[l][RB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_valid   = vld_reg[RB-1];
    assign out_far     = far_reg[RB-1];
    assign out_root[0] = root_reg[RB-1][0];
    assign out_root[1] = root_reg[RB-1][1];

endmodule

[rtl/gcpt_back.sv]
// ----------------------------------------------------------------------------
// gcpt_back
// Distance difference, saturation, threshold flags and result register.
// ----------------------------------------------------------------------------
module gcpt_back #(
    parameter int COORD_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic                        in_far,
    input  logic [COORD_BITS:0]         scene_root,
    input  logic [COORD_BITS:0]         model_root,
    input  gcpt_pkg::cfg_t              cfg,
    output logic                        out_valid,
    output logic [gcpt_pkg::DIST_W-1:0] out_distance,
    output logic                        out_far,
    output logic                        out_candidate,
    output logic                        out_consistent
);
    import gcpt_pkg::*;

    localparam int RB = COORD_BITS + 1;
    localparam int DW = ((RB > DIST_W) ? RB : DIST_W) + 1;

    logic [RB-1:0]     diff;
    logic [DW-1:0]     diff_ext;
    logic [DIST_W-1:0] dist_next, dist_reg;
    logic              va_reg, fa_reg;
    logic              vo_reg, fo_reg, co_reg, ko_reg;
    logic [DIST_W-1:0] do_reg;

    always_comb begin
        diff      = (scene_root >= model_root) ? scene_root - model_root
                                               : model_root - scene_root;
        diff_ext  = {{(DW-RB){1'b0}}, diff};
        if (in_far || diff_ext > {{(DW-DIST_W){1'b0}}, DIST_MAX}) begin
            dist_next = DIST_MAX;
        end else begin
            dist_next = diff_ext[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vo_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
            fa_reg   <= in_far;
            do_reg   <= dist_reg;
            fo_reg   <= fa_reg;
            co_reg   <= !fa_reg && (dist_reg <= cfg.candidate_limit);
            ko_reg   <= !fa_reg && (dist_reg <= cfg.consistency_resolution);
        end
    end

    assign out_valid      = vo_reg;
    assign out_distance   = do_reg;
    assign out_far        = fo_reg;
    assign out_candidate  = co_reg;
    assign out_consistent = ko_reg;

endmodule

[rtl/gcpt_checker.sv]
// ----------------------------------------------------------------------------
// gcpt_checker
// Port-level assertions for the pairwise geometric consistency test.
// ----------------------------------------------------------------------------
module gcpt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [gcpt_pkg::DIST_W-1:0] m_pair_distance,
    input logic                        m_out_of_reach,
    input logic                        m_is_candidate,
    input logic                        m_is_consistent
);
    import gcpt_pkg::*;

    // The output is empty straight after reset.
    assert property (@(posedge aclk) !$past(aresetn) |-> !m_valid)
        else $error("result valid just after reset");

    // A held result keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pair_distance)
            && $stable(m_out_of_reach) && $stable(m_is_candidate)
            && $stable(m_is_consistent))
        else $error("stalled result changed");

    // Requests are refused only while a result waits to be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request refused without output stall");

    // An out-of-reach pair reports the saturated distance and no flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_reach |-> m_pair_distance == DIST_MAX
            && !m_is_candidate && !m_is_consistent)
        else $error("out-of-reach result malformed");

endmodule

bind geometric_consistency_pair_test gcpt_checker u_gcpt_checker (.*);

[test/geometric_consistency_pair_test_tb.sv]
// ----------------------------------------------------------------------------
// geometric_consistency_pair_test_tb
// Self-checking bench for the pairwise geometric consistency distance block.
// ----------------------------------------------------------------------------
// Requests carrying two model/scene correspondences are pushed through the
// block while both handshakes idle at random. Every accepted request is
// predicted by an independent integer model of the distance test, and every
// result is compared with the oldest outstanding prediction. The limits are
// reprogrammed through the APB-style port between phases, once the pipeline
// has drained, and cover the reset values, all-zero and all-ones settings.
// ----------------------------------------------------------------------------
module geometric_consistency_pair_test_tb;

    import gcpt_pkg::*;

    localparam int COORD_BITS = 20;
    localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

    // Pipeline depth of the block, plus some margin.
    localparam int LATENCY        = COORD_BITS + 6;
    localparam int DRAIN_CYCLES   = LATENCY + 8;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 242;
    localparam int PRESSURE_PHASE  = 2;

    // Register index that decodes to nothing; writes there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Coordinate triple: element 0 is x, 1 is y and 2 is z.
    typedef logic [2:0][COORD_BITS-1:0] point_t;

    typedef struct packed {
        point_t model_a;
        point_t scene_a;
        point_t model_b;
        point_t scene_b;
    } pair_request_t;

    typedef struct packed {
        logic [DIST_W-1:0] pair_distance;
        logic              out_of_reach;
        logic              is_candidate;
        logic              is_consistent;
    } pair_result_t;

    // ------------------------------------------------------------------------
    // Tracker of expected pair results. It keeps its own copy of the three
    // limits and predicts the result of each request at the moment the
    // request is accepted; the limits only change while the block is idle.
    // ------------------------------------------------------------------------
    class pair_result_tracker;
        localparam int MAX_REPORTS = 100;

        logic [DIST_W-1:0] reach_limit;
        logic [DIST_W-1:0] candidate_limit;
        logic [DIST_W-1:0] consistency_resolution;
        pair_result_t      awaited[$];
        int unsigned       mismatches;

        function new();
            reach_limit            = DIST_MAX;
            candidate_limit        = '0;
            consistency_resolution = '0;
            mismatches             = 0;
        endfunction

        // Only the low 22 bits of a written word reach a limit.
        function void set_register(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_REACH: reach_limit            = value[DIST_W-1:0];
                REG_CAND:  candidate_limit        = value[DIST_W-1:0];
                REG_CONS:  consistency_resolution = value[DIST_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned separation_sq(point_t p, point_t q);
            longint            d;
            longint unsigned   acc = 0;
            for (int k = 0; k < 3; k++) begin
                d   = longint'($signed(p[k])) - longint'($signed(q[k]));
                acc = acc + longint'(d * d);
            end
            return acc;
        endfunction

        // Largest r with r*r <= n, built one bit at a time from the top.
        function longint unsigned floor_root(longint unsigned n);
            longint unsigned root = 0;
            longint unsigned trial;
            for (int b = 25; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= n) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function void note_request(pair_request_t rq);
            longint unsigned scene_sq;
            longint unsigned reach_sq;
            longint unsigned scene_d;
            longint unsigned model_d;
            longint unsigned diff;
            pair_result_t    want;
            scene_sq = separation_sq(rq.scene_a, rq.scene_b);
            reach_sq = longint'(reach_limit) * longint'(reach_limit);
            want.out_of_reach = (scene_sq > reach_sq);
            if (want.out_of_reach) begin
                want.pair_distance = DIST_MAX;
            end else begin
                scene_d = floor_root(scene_sq);
                model_d = floor_root(separation_sq(rq.model_a, rq.model_b));
                diff    = (scene_d >= model_d) ? scene_d - model_d : model_d - scene_d;
                want.pair_distance = (diff > DIST_MAX) ? DIST_MAX : diff[DIST_W-1:0];
            end
            // An out-of-reach pair stands for infinity and passes no threshold.
            want.is_candidate  = !want.out_of_reach && (want.pair_distance <= candidate_limit);
            want.is_consistent = !want.out_of_reach
                                 && (want.pair_distance <= consistency_resolution);
            awaited.insert(awaited.size(), want);
        endfunction

        function void check_result(pair_result_t got);
            pair_result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: expected nothing, got dist=%0d far=%0b cand=%0b cons=%0b",
                             $time, got.pair_distance, got.out_of_reach, got.is_candidate,
                             got.is_consistent);
                end
                return;
            end
            want = awaited.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
                             $time, want.pair_distance, want.out_of_reach, want.is_candidate,
                             want.is_consistent, got.pair_distance, got.out_of_reach,
                             got.is_candidate, got.is_consistent);
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic                aclk;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pair_request_t       offered = '0;
    logic                m_valid;
    logic                m_ready = 1'b1;
    logic [DIST_W-1:0]   m_pair_distance;
    logic                m_out_of_reach;
    logic                m_is_candidate;
    logic                m_is_consistent;

    pair_result_tracker  tracker = new();

    // Percent chance of a gap per request and of a stall per cycle, per phase.
    int                  tx_gap_pct   = 0;
    int                  rx_stall_pct = 0;
    bit                  long_hold_due = 1'b0;
    int                  quiet_cycles = 0;

    geometric_consistency_pair_test #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_model_a_x    (offered.model_a[0]),
        .s_model_a_y    (offered.model_a[1]),
        .s_model_a_z    (offered.model_a[2]),
        .s_scene_a_x    (offered.scene_a[0]),
        .s_scene_a_y    (offered.scene_a[1]),
        .s_scene_a_z    (offered.scene_a[2]),
        .s_model_b_x    (offered.model_b[0]),
        .s_model_b_y    (offered.model_b[1]),
        .s_model_b_z    (offered.model_b[2]),
        .s_scene_b_x    (offered.scene_b[0]),
        .s_scene_b_y    (offered.scene_b[1]),
        .s_scene_b_z    (offered.scene_b[2]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pair_distance(m_pair_distance),
        .m_out_of_reach (m_out_of_reach),
        .m_is_candidate (m_is_candidate),
        .m_is_consistent(m_is_consistent)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Both channels are sampled at the rising edge, before any of the
    // nonblocking updates of that edge take effect, so the order in which
    // processes wake within the time step does not matter.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            tracker.note_request(offered);
        end
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result({m_pair_distance, m_out_of_reach, m_is_candidate,
                                  m_is_consistent});
        end
    end

    // The run is abandoned when neither channel has moved for too long. The
    // longest legitimate quiet spell is the receiver's long hold-off.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Result side: random stalls, and once a long hold-off so that the pipeline
    // fills and the block pushes back.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // A register write: setup cycle, then the access cycle at whose closing
    // edge the block takes the value, then the port returns to idle so that
    // a following write starts cleanly. pready is always high.
    task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
        @(posedge aclk);
    endtask

    // Offers one request and returns at the edge that accepts it. A gap, if
    // one is drawn, is taken before the request is raised.
    task automatic send_request(input pair_request_t rq);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        offered <= rq;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Lets the last acceptance be noted, then waits until every predicted result
    // has come back, then for the pipeline depth.
    task automatic settle();
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic point_t pt(int x, int y, int z);
        point_t p;
        p[0] = COORD_BITS'(x);
        p[1] = COORD_BITS'(y);
        p[2] = COORD_BITS'(z);
        return p;
    endfunction

    task automatic send_points(input point_t ma, input point_t sa, input point_t mb,
                               input point_t sb);
        send_request('{model_a: ma, scene_a: sa, model_b: mb, scene_b: sb});
    endtask

    // Uniform offset in the range -2^s .. +2^s.
    function automatic int offset_within(int s);
        return int'($urandom_range(0, 2 << s)) - (1 << s);
    endfunction

    // Most requests are congruent pairs: the scene displacement is the model
    // displacement with its axes rotated and mirrored, so the two distances
    // agree up to a little optional noise and the thresholds see small values.
    // The rest are tight clusters and fully random coordinates.
    function automatic pair_request_t random_request();
        pair_request_t rq;
        int            scale;
        int            twist;
        int            fuzz;
        bit            noisy;
        int            base_m;
        int            base_s;
        int            step;
        int            delta[3];
        scale = $urandom_range(0, 18);
        case ($urandom_range(0, 9))
            0, 1: begin
                for (int k = 0; k < 3; k++) begin
                    rq.model_a[k] = COORD_BITS'($urandom());
                    rq.scene_a[k] = COORD_BITS'($urandom());
                    rq.model_b[k] = COORD_BITS'($urandom());
                    rq.scene_b[k] = COORD_BITS'($urandom());
                end
            end
            8, 9: begin
                for (int k = 0; k < 3; k++) begin
                    base_m = offset_within(18);
                    rq.model_a[k] = COORD_BITS'(base_m + offset_within(scale));
                    rq.scene_a[k] = COORD_BITS'(base_m + offset_within(scale));
                    rq.model_b[k] = COORD_BITS'(base_m + offset_within(scale));
                    rq.scene_b[k] = COORD_BITS'(base_m + offset_within(scale));
                end
            end
            default: begin
                twist = $urandom_range(0, 2);
                fuzz  = $urandom_range(0, scale);
                noisy = ($urandom_range(0, 2) != 0);
                for (int k = 0; k < 3; k++) begin
                    delta[k] = offset_within(scale);
                end
                for (int k = 0; k < 3; k++) begin
                    base_m = offset_within(18);
                    base_s = offset_within(18);
                    step   = delta[(k + twist) % 3];
                    if ($urandom_range(0, 1) != 0) begin
                        step = -step;
                    end
                    if (noisy) begin
                        step = step + offset_within(fuzz);
                    end
                    rq.model_a[k] = COORD_BITS'(base_m);
                    rq.model_b[k] = COORD_BITS'(base_m + delta[k]);
                    rq.scene_a[k] = COORD_BITS'(base_s);
                    rq.scene_b[k] = COORD_BITS'(base_s + step);
                end
            end
        endcase
        return rq;
    endfunction

    // Limits spread over many magnitudes, with junk above the register width
    // now and then, which the block must drop.
    function automatic logic [DATA_W-1:0] random_limit();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = DATA_W'(DIST_MAX);
            2:       v = DATA_W'($urandom_range(0, 64));
            3:       v = DATA_W'($urandom_range(0, 1 << $urandom_range(1, 21)));
            default: v = DATA_W'($urandom_range(0, DIST_MAX));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            v[DATA_W-1:DIST_W] = (DATA_W - DIST_W)'($urandom());
        end
        return v;
    endfunction

    function automatic int random_idle_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [DATA_W-1:0] reach_word;
        logic [DATA_W-1:0] cand_word;
        logic [DATA_W-1:0] cons_word;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests under the reset limits: everything is in reach
        // and only a zero pair distance passes the thresholds.
        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0));
        send_points(pt(0, 0, 0), pt(COORD_MIN, COORD_MIN, COORD_MIN),
                    pt(0, 0, 0), pt(COORD_MAX, COORD_MAX, COORD_MAX));
        send_points(pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(0, 0, 0),
                    pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(0, 0, 0));
        send_points(pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MAX, COORD_MAX, COORD_MAX),
                    pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(COORD_MIN, COORD_MIN, COORD_MIN));
        send_points(pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MAX, COORD_MIN, COORD_MAX),
                    pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(COORD_MIN, COORD_MAX, COORD_MIN));
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(-1, 0, 0));
        send_points(pt(-1, -1, -1), pt(-1, -1, -1), pt(0, 0, 0), pt(0, 0, 0));
        s_valid <= 1'b0;
        settle();

        // A reach limit of 1000 with junk in the upper bits of every word; a
        // write to the unused address must change nothing.
        write_register(REG_REACH, 32'hFFC0_03E8);
        write_register(REG_CAND,  32'h8000_0003);
        write_register(REG_CONS,  32'hFFC0_0000);
        write_register(REG_UNUSED, 32'h0000_0001);

        // Right on the reach limit, one beyond it, and one whose floored
        // distance equals the limit while the exact separation exceeds it.
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(1000, 0, 0));
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(1001, 0, 0));
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(1000, 1, 0));
        // Pair distance at the candidate limit, and one above it.
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 997), pt(600, 800, 0));
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 996), pt(600, 800, 0));
        // Congruent pair with the axes swapped, so nothing separates them.
        send_points(pt(0, 0, 0), pt(5, 5, 5), pt(600, 0, 800), pt(605, 805, 5));
        // Coincident scene points against a distant model pair.
        send_points(pt(COORD_MIN, 0, 0), pt(7, 7, 7), pt(COORD_MAX, 0, 0), pt(7, 7, 7));
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(-1000, 0, 0));
        s_valid <= 1'b0;
        settle();

        // A zero reach limit with the thresholds wide open: only coincident
        // scene points stay in reach, and out-of-reach pairs must still fail
        // both thresholds.
        write_register(REG_REACH, 32'h0000_0000);
        write_register(REG_CAND,  DATA_W'(DIST_MAX));
        write_register(REG_CONS,  32'hFFFF_FFFF);
        send_points(pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(3, -3, 3),
                    pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(3, -3, 3));
        send_points(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 1));
        s_valid <= 1'b0;
        settle();

        // Random phases. The first two pin every limit to its top and bottom
        // value; one phase carries the long receiver hold-off while the
        // sender keeps offering, and the final phase runs with no idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                reach_word = DATA_W'(DIST_MAX);
                cand_word  = DATA_W'(DIST_MAX);
                cons_word  = DATA_W'(DIST_MAX);
            end else if (phase == 1) begin
                reach_word = '0;
                cand_word  = '0;
                cons_word  = '0;
            end else begin
                reach_word = random_limit();
                cand_word  = random_limit();
                cons_word  = random_limit();
            end
            write_register(REG_REACH, reach_word);
            write_register(REG_CAND,  cand_word);
            write_register(REG_CONS,  cons_word);
            if ($urandom_range(0, 2) == 0) begin
                write_register(REG_UNUSED, $urandom());
            end

            if (phase == RANDOM_PHASES - 1) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else if (phase == PRESSURE_PHASE) begin
                tx_gap_pct    = 0;
                rx_stall_pct  = random_idle_rate();
                long_hold_due = 1'b1;
            end else begin
                tx_gap_pct   = random_idle_rate();
                rx_stall_pct = random_idle_rate();
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_request(random_request());
            end
            s_valid <= 1'b0;
            settle();
        end

        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/gcpt_pkg.sv
rtl/gcpt_regs.sv
rtl/gcpt_front.sv
rtl/gcpt_root_pipe.sv
rtl/gcpt_back.sv
rtl/geometric_consistency_pair_test.sv
rtl/gcpt_checker.sv
test/geometric_consistency_pair_test_tb.sv
